@@ sv/bco_pkg.sv @@
package bco_pkg;

    // Collider shape codes.
    typedef enum logic {
        KIND_BOX = 1'b0,
        KIND_CYL = 1'b1
    } bco_kind_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KIND = 3'd0,
        REG_AX   = 3'd1,
        REG_AY   = 3'd2,
        REG_AZ   = 3'd3,
        REG_BX   = 3'd4,
        REG_BY   = 3'd5,
        REG_BZ   = 3'd6
    } bco_reg_t;

    localparam int unsigned REG_INDEX_BITS = 3;

    // Flags that the span stage hands to the distance stage.
    typedef struct packed {
        logic mixed;    // one box and one cylinder
        logic pre_hit;  // bounding boxes overlap
    } bco_flags_t;

endpackage

@@ sv/box_cylinder_overlap_test.sv @@
// Channel   Direction  Handshake                     Payload
// item      in         item_valid / item_stall       item_kind, item_ax .. item_bz
// result    out        result_valid / result_stall   hit
// cfg       in         cfg_valid / cfg_ready         cfg_index, cfg_data
//
// One beat is accepted per cycle while item_stall is low; each beat passes
// through the input register and then the result register.
// The bounding boxes, gaps, squaring and radius compare all sit between the
// input register and the result register.
// rst_n clears all valid bits and the reference collider to a zero box.
// A stalled result holds the pipeline; item_stall rises only once both
// registers hold a beat.
module box_cylinder_overlap_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                item_kind,
    input  logic signed [COORD_BITS-1:0]        item_ax,
    input  logic signed [COORD_BITS-1:0]        item_ay,
    input  logic signed [COORD_BITS-1:0]        item_az,
    input  logic signed [COORD_BITS-1:0]        item_bx,
    input  logic signed [COORD_BITS-1:0]        item_by,
    input  logic signed [COORD_BITS-1:0]        item_bz,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                hit,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bco_pkg::REG_INDEX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data
);

    logic                          ref_kind;
    logic signed [COORD_BITS-1:0]  ref_ax, ref_ay, ref_az, ref_bx, ref_by, ref_bz;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_kind_reg;
    logic signed [COORD_BITS-1:0]  s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic signed [COORD_BITS-1:0]  s1_bx_reg, s1_by_reg, s1_bz_reg;

    bco_pkg::bco_flags_t           span_flags;
    logic [COORD_BITS+1:0]         span_gap_x, span_gap_z;
    logic [COORD_BITS:0]           span_rad2;

    logic                          dist_hit;
    logic                          res_valid_reg, res_valid_next;
    logic                          hit_reg;

    logic                          res_free, s1_free;

    // Reference collider registers.
    bco_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ref_kind  (ref_kind),
        .ref_ax    (ref_ax),
        .ref_ay    (ref_ay),
        .ref_az    (ref_az),
        .ref_bx    (ref_bx),
        .ref_by    (ref_by),
        .ref_bz    (ref_bz)
    );

    // Each stage loads when it is empty or its beat moves on.
    assign res_free   = !res_valid_reg || !result_stall;
    assign s1_free    = !s1_valid_reg || res_free;
    assign item_stall = !s1_free;

    assign s1_valid_next  = s1_free  ? item_valid   : s1_valid_reg;
    assign res_valid_next = res_free ? s1_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_kind_reg <= item_kind;
            s1_ax_reg   <= item_ax;
            s1_ay_reg   <= item_ay;
            s1_az_reg   <= item_az;
            s1_bx_reg   <= item_bx;
            s1_by_reg   <= item_by;
            s1_bz_reg   <= item_bz;
        end
    end

    // Bounding boxes, overlap and axis gaps.
    bco_span #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .ref_kind  (ref_kind),
        .ref_ax    (ref_ax),
        .ref_ay    (ref_ay),
        .ref_az    (ref_az),
        .ref_bx    (ref_bx),
        .ref_by    (ref_by),
        .ref_bz    (ref_bz),
        .item_kind (s1_kind_reg),
        .item_ax   (s1_ax_reg),
        .item_ay   (s1_ay_reg),
        .item_az   (s1_az_reg),
        .item_bx   (s1_bx_reg),
        .item_by   (s1_by_reg),
        .item_bz   (s1_bz_reg),
        .flags     (span_flags),
        .gap_x     (span_gap_x),
        .gap_z     (span_gap_z),
        .rad2      (span_rad2)
    );

    // Radius test of a mixed pair.
    bco_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .flags (span_flags),
        .gap_x (span_gap_x),
        .gap_z (span_gap_z),
        .rad2  (span_rad2),
        .hit   (dist_hit)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (res_free)
        begin
            hit_reg <= dist_hit;
        end
    end

    assign result_valid = res_valid_reg;
    assign hit          = hit_reg;

endmodule

@@ sv/bco_cfg.sv @@
module bco_cfg #(
    parameter int COORD_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [bco_pkg::REG_INDEX_BITS-1:0]        cfg_index,
    input  logic [COORD_BITS-1:0]                     cfg_data,
    output logic                                      ref_kind,
    output logic signed [COORD_BITS-1:0]              ref_ax,
    output logic signed [COORD_BITS-1:0]              ref_ay,
    output logic signed [COORD_BITS-1:0]              ref_az,
    output logic signed [COORD_BITS-1:0]              ref_bx,
    output logic signed [COORD_BITS-1:0]              ref_by,
    output logic signed [COORD_BITS-1:0]              ref_bz
);

    logic                          kind_reg;
    logic signed [COORD_BITS-1:0]  ax_reg;
    logic signed [COORD_BITS-1:0]  ay_reg;
    logic signed [COORD_BITS-1:0]  az_reg;
    logic signed [COORD_BITS-1:0]  bx_reg;
    logic signed [COORD_BITS-1:0]  by_reg;
    logic signed [COORD_BITS-1:0]  bz_reg;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // Register file; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            ax_reg   <= '0;
            ay_reg   <= '0;
            az_reg   <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            bz_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bco_pkg::REG_KIND: kind_reg <= cfg_data[0];
                bco_pkg::REG_AX:   ax_reg   <= cfg_data;
                bco_pkg::REG_AY:   ay_reg   <= cfg_data;
                bco_pkg::REG_AZ:   az_reg   <= cfg_data;
                bco_pkg::REG_BX:   bx_reg   <= cfg_data;
                bco_pkg::REG_BY:   by_reg   <= cfg_data;
                bco_pkg::REG_BZ:   bz_reg   <= cfg_data;
                default:           kind_reg <= kind_reg;
            endcase
        end
    end

    assign ref_kind = kind_reg;
    assign ref_ax   = ax_reg;
    assign ref_ay   = ay_reg;
    assign ref_az   = az_reg;
    assign ref_bx   = bx_reg;
    assign ref_by   = by_reg;
    assign ref_bz   = bz_reg;

endmodule

@@ sv/bco_span.sv @@
module bco_span #(
    parameter int COORD_BITS = 16
) (
    input  logic                          ref_kind,
    input  logic signed [COORD_BITS-1:0]  ref_ax,
    input  logic signed [COORD_BITS-1:0]  ref_ay,
    input  logic signed [COORD_BITS-1:0]  ref_az,
    input  logic signed [COORD_BITS-1:0]  ref_bx,
    input  logic signed [COORD_BITS-1:0]  ref_by,
    input  logic signed [COORD_BITS-1:0]  ref_bz,
    input  logic                          item_kind,
    input  logic signed [COORD_BITS-1:0]  item_ax,
    input  logic signed [COORD_BITS-1:0]  item_ay,
    input  logic signed [COORD_BITS-1:0]  item_az,
    input  logic signed [COORD_BITS-1:0]  item_bx,
    input  logic signed [COORD_BITS-1:0]  item_by,
    input  logic signed [COORD_BITS-1:0]  item_bz,
    output bco_pkg::bco_flags_t           flags,
    output logic [COORD_BITS+1:0]         gap_x,
    output logic [COORD_BITS+1:0]         gap_z,
    output logic [COORD_BITS:0]           rad2
);

    // Extended width: holds every span bound and every doubled-unit sum.
    localparam int EW = COORD_BITS + 3;

    logic                  ref_cyl;
    logic                  item_cyl;
    logic signed [EW-1:0]  r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [EW-1:0]  i_ax, i_ay, i_az, i_bx, i_by, i_bz;
    logic signed [EW-1:0]  r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic signed [EW-1:0]  i_x0, i_x1, i_y0, i_y1, i_z0, i_z1;
    logic                  overlap;
    logic signed [EW-1:0]  cx, cz, rad;
    logic signed [EW-1:0]  bx0, bx1, bz0, bz1;
    logic signed [EW-1:0]  sx, sz, mx, mz, dx, dz, rmag;

    assign ref_cyl  = (ref_kind == bco_pkg::KIND_CYL);
    assign item_cyl = (item_kind == bco_pkg::KIND_CYL);

    // Sign extension of both colliders.
    assign r_ax = EW'(ref_ax);
    assign r_ay = EW'(ref_ay);
    assign r_az = EW'(ref_az);
    assign r_bx = EW'(ref_bx);
    assign r_by = EW'(ref_by);
    assign r_bz = EW'(ref_bz);
    assign i_ax = EW'(item_ax);
    assign i_ay = EW'(item_ay);
    assign i_az = EW'(item_az);
    assign i_bx = EW'(item_bx);
    assign i_by = EW'(item_by);
    assign i_bz = EW'(item_bz);

    // Bounding boxes; a cylinder spans centre plus or minus radius in x and z.
    assign r_x0 = ref_cyl ? r_ax - r_bx : r_ax;
    assign r_x1 = ref_cyl ? r_ax + r_bx : r_bx;
    assign r_y0 = r_ay;
    assign r_y1 = ref_cyl ? r_ay + r_by : r_by;
    assign r_z0 = ref_cyl ? r_az - r_bx : r_az;
    assign r_z1 = ref_cyl ? r_az + r_bx : r_bz;

    assign i_x0 = item_cyl ? i_ax - i_bx : i_ax;
    assign i_x1 = item_cyl ? i_ax + i_bx : i_bx;
    assign i_y0 = i_ay;
    assign i_y1 = item_cyl ? i_ay + i_by : i_by;
    assign i_z0 = item_cyl ? i_az - i_bx : i_az;
    assign i_z1 = item_cyl ? i_az + i_bx : i_bz;

    // Bounding-box overlap; touching counts. For a mixed pair this also
    // covers the vertical span test.
    assign overlap = !((r_x1 < i_x0) || (r_x0 > i_x1) ||
                       (r_y1 < i_y0) || (r_y0 > i_y1) ||
                       (r_z1 < i_z0) || (r_z0 > i_z1));

    assign flags.mixed   = (ref_cyl != item_cyl);
    assign flags.pre_hit = overlap;

    // Pick the cylinder and the box of a mixed pair.
    assign cx  = ref_cyl ? r_ax : i_ax;
    assign cz  = ref_cyl ? r_az : i_az;
    assign rad = ref_cyl ? r_bx : i_bx;
    assign bx0 = ref_cyl ? i_ax : r_ax;
    assign bx1 = ref_cyl ? i_bx : r_bx;
    assign bz0 = ref_cyl ? i_az : r_az;
    assign bz1 = ref_cyl ? i_bz : r_bz;

    // Doubled-unit gap from the axis to the box, clamped at zero.
    assign sx = bx0 + bx1 - (cx + cx);
    assign sz = bz0 + bz1 - (cz + cz);
    assign mx = sx[EW-1] ? -sx : sx;
    assign mz = sz[EW-1] ? -sz : sz;
    assign dx = mx - (bx1 - bx0);
    assign dz = mz - (bz1 - bz0);

    assign gap_x = (dx > 0) ? dx[COORD_BITS+1:0] : '0;
    assign gap_z = (dz > 0) ? dz[COORD_BITS+1:0] : '0;

    // Doubled radius by magnitude.
    assign rmag = rad[EW-1] ? -rad : rad;
    assign rad2 = {rmag[COORD_BITS-1:0], 1'b0};

endmodule

@@ sv/bco_dist.sv @@
module bco_dist #(
    parameter int COORD_BITS = 16
) (
    input  bco_pkg::bco_flags_t    flags,
    input  logic [COORD_BITS+1:0]  gap_x,
    input  logic [COORD_BITS+1:0]  gap_z,
    input  logic [COORD_BITS:0]    rad2,
    output logic                   hit
);

    localparam int GW = COORD_BITS + 2;
    localparam int RW = COORD_BITS + 1;
    localparam int SW = 2 * GW + 1;

    logic [2*GW-1:0]  sq_x;
    logic [2*GW-1:0]  sq_z;
    logic [2*RW-1:0]  sq_r;
    logic [SW-1:0]    lhs;
    logic             inside_r;

    // Squared distance against squared radius, all in doubled units.
    assign sq_x     = (2*GW)'(gap_x) * (2*GW)'(gap_x);
    assign sq_z     = (2*GW)'(gap_z) * (2*GW)'(gap_z);
    assign sq_r     = (2*RW)'(rad2) * (2*RW)'(rad2);
    assign lhs      = SW'(sq_x) + SW'(sq_z);
    assign inside_r = (lhs <= SW'(sq_r));

    // Same-shape pairs rest on bounding-box overlap alone.
    assign hit = flags.pre_hit && (!flags.mixed || inside_r);

endmodule

@@ tb/testbench.sv @@
module testbench;

    localparam int COORD_BITS = 16;
    localparam int LATENCY = 2;
    localparam int PHASES = 8;
    localparam int PHASE_BEATS = 50;
    localparam logic [bco_pkg::REG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One collider: a box (min and max corners) or an upright cylinder.
    typedef struct packed {
        bco_pkg::bco_kind_t kind;
        coord_t             ax;
        coord_t             ay;
        coord_t             az;
        coord_t             bx;
        coord_t             by;
        coord_t             bz;
    } collider_t;

    // Bounding box with widened corners.
    typedef struct packed {
        longint x0;
        longint y0;
        longint z0;
        longint x1;
        longint y1;
        longint z1;
    } extent_t;

    typedef enum logic [1:0] {
        WANT_MISS,
        WANT_HIT,
        WANT_MODEL
    } want_t;

    typedef struct packed {
        collider_t refc;
        collider_t item;
        want_t     want;
    } probe_row_t;

    // Reference colliders used by the directed probes.
    localparam collider_t ZERO_BOX = '{bco_pkg::KIND_BOX, 0, 0, 0, 0, 0, 0};
    localparam collider_t POST = '{bco_pkg::KIND_CYL, 0, 0, 0, 16, 32, 0};
    localparam collider_t WIDE_CYL =
        '{bco_pkg::KIND_CYL, -32768, -32768, 32767, 32767, 32767, -32768};
    localparam collider_t FULL_BOX =
        '{bco_pkg::KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767};
    localparam collider_t FLIP_BOX =
        '{bco_pkg::KIND_BOX, 100, 100, 100, -100, -100, -100};

    // Directed probes. The first ones run against the reset reference.
    localparam probe_row_t PROBES [25] = '{
        '{ZERO_BOX, '{bco_pkg::KIND_BOX, 0, 0, 0, 0, 0, 0}, WANT_HIT},
        '{ZERO_BOX, '{bco_pkg::KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767},
          WANT_HIT},
        '{ZERO_BOX, '{bco_pkg::KIND_BOX, 32767, 32767, 32767, 32767, 32767, 32767},
          WANT_MISS},
        '{ZERO_BOX, '{bco_pkg::KIND_BOX, -32768, -32768, -32768, -32768, -32768, -32768},
          WANT_MISS},
        '{ZERO_BOX, '{bco_pkg::KIND_BOX, 1, 1, 1, -1, -1, -1}, WANT_MISS},
        '{ZERO_BOX, '{bco_pkg::KIND_CYL, 0, 0, 0, 0, 0, 0}, WANT_HIT},
        '{ZERO_BOX, '{bco_pkg::KIND_CYL, 0, 0, 0, -1, 4, 0}, WANT_MISS},
        '{ZERO_BOX, '{bco_pkg::KIND_CYL, 0, 0, 0, 4, -1, 0}, WANT_MISS},
        '{ZERO_BOX, '{bco_pkg::KIND_CYL, 16, 0, 0, 16, 8, 0}, WANT_HIT},
        '{ZERO_BOX, '{bco_pkg::KIND_CYL, -16, -8, 0, 16, 8, -32768}, WANT_HIT},
        '{POST, '{bco_pkg::KIND_BOX, 12, 0, 12, 20, 8, 20}, WANT_MODEL},
        '{POST, '{bco_pkg::KIND_BOX, 10, 0, 10, 20, 8, 20}, WANT_MODEL},
        '{POST, '{bco_pkg::KIND_BOX, -4, 33, -4, 4, 40, 4}, WANT_MODEL},
        '{POST, '{bco_pkg::KIND_BOX, -4, 32, -4, 4, 40, 4}, WANT_MODEL},
        '{POST, '{bco_pkg::KIND_CYL, 40, 0, 0, 24, 8, 0}, WANT_MODEL},
        '{POST, '{bco_pkg::KIND_CYL, 40, 0, 40, 24, 8, 0}, WANT_MODEL},
        '{POST, '{bco_pkg::KIND_BOX, 20, -8, 20, 12, 40, 12}, WANT_MODEL},
        '{WIDE_CYL, '{bco_pkg::KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767},
          WANT_MODEL},
        '{WIDE_CYL, '{bco_pkg::KIND_BOX, 32767, 32767, -32768, 32767, 32767, -32768},
          WANT_MODEL},
        '{WIDE_CYL, '{bco_pkg::KIND_CYL, 32767, 32767, 32767, -32768, -32768, 0},
          WANT_MODEL},
        '{FULL_BOX, '{bco_pkg::KIND_CYL, 32767, -32768, 32767, 32767, 32767, 32767},
          WANT_MODEL},
        '{FULL_BOX, '{bco_pkg::KIND_CYL, -32768, 0, -32768, -32768, 100, 0}, WANT_MODEL},
        '{FULL_BOX, '{bco_pkg::KIND_BOX, 0, 0, 0, 0, 0, 0}, WANT_MODEL},
        '{FLIP_BOX, '{bco_pkg::KIND_CYL, 0, 0, 0, 200, 50, 0}, WANT_MODEL},
        '{FLIP_BOX, '{bco_pkg::KIND_BOX, -100, -100, -100, 100, 100, 100}, WANT_MODEL}
    };

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               item_valid = 1'b0;
    logic                               item_stall;
    logic                               item_kind = 1'b0;
    coord_t                             item_ax = '0;
    coord_t                             item_ay = '0;
    coord_t                             item_az = '0;
    coord_t                             item_bx = '0;
    coord_t                             item_by = '0;
    coord_t                             item_bz = '0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic                               hit;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [bco_pkg::REG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0]              cfg_data = '0;

    // Copy of the reference collider as the block should hold it.
    collider_t shape_ref = ZERO_BOX;
    logic      hits_due [$];
    logic      due_hit;
    logic      calm = 1'b0;
    int        mismatches = 0;

    box_cylinder_overlap_test #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_kind   (item_kind),
        .item_ax     (item_ax),
        .item_ay     (item_ay),
        .item_az     (item_az),
        .item_bx     (item_bx),
        .item_by     (item_by),
        .item_bz     (item_bz),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .hit         (hit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Bounding box of a collider; a cylinder spans centre +- radius in x and z.
    function automatic extent_t extent_of(input collider_t c);
        extent_t e;
        if (c.kind == bco_pkg::KIND_CYL)
        begin
            e.x0 = $signed(c.ax) - $signed(c.bx);
            e.x1 = $signed(c.ax) + $signed(c.bx);
            e.y0 = $signed(c.ay);
            e.y1 = $signed(c.ay) + $signed(c.by);
            e.z0 = $signed(c.az) - $signed(c.bx);
            e.z1 = $signed(c.az) + $signed(c.bx);
        end
        else
        begin
            e.x0 = $signed(c.ax);
            e.y0 = $signed(c.ay);
            e.z0 = $signed(c.az);
            e.x1 = $signed(c.bx);
            e.y1 = $signed(c.by);
            e.z1 = $signed(c.bz);
        end
        return e;
    endfunction

    // Touching faces count as overlap; inverted corners are used as given.
    function automatic logic boxes_touch(input extent_t a, input extent_t b);
        return !(a.x1 < b.x0 || a.x0 > b.x1 ||
                 a.y1 < b.y0 || a.y0 > b.y1 ||
                 a.z1 < b.z0 || a.z0 > b.z1);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Distance from the axis to the box along one axis, in doubled units.
    function automatic longint axis_gap(input longint lo, input longint hi, input longint c);
        longint d;
        d = magnitude(lo + hi - 2 * c) - (hi - lo);
        return (d > 0) ? d : 0;
    endfunction

    function automatic logic cylinder_meets_box(input collider_t cyl, input extent_t ce,
                                                input extent_t be);
        longint gx;
        longint gz;
        longint span;
        if (!boxes_touch(ce, be))
            return 1'b0;
        gx = axis_gap(be.x0, be.x1, $signed(cyl.ax));
        gz = axis_gap(be.z0, be.z1, $signed(cyl.az));
        span = 2 * magnitude($signed(cyl.bx));
        if (gx * gx + gz * gz > span * span)
            return 1'b0;
        return ce.y0 <= be.y1 && ce.y1 >= be.y0;
    endfunction

    // Expected hit of one tested collider against the current reference.
    function automatic logic predict_hit(input collider_t item);
        extent_t re;
        extent_t ie;
        re = extent_of(shape_ref);
        ie = extent_of(item);
        if (shape_ref.kind == item.kind)
            return boxes_touch(re, ie);
        if (shape_ref.kind == bco_pkg::KIND_CYL)
            return cylinder_meets_box(shape_ref, re, ie);
        return cylinder_meets_box(item, ie, re);
    endfunction

    // Wait cycles before a beat; none at all while the phase runs calm.
    function automatic int idle_draw();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic coord_t clip(input int v);
        if (v > 32767)
            return coord_t'(32767);
        if (v < -32768)
            return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return coord_t'(-32768);
            1: return coord_t'(32767);
            2: return coord_t'(0);
            3: return coord_t'(-1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Reference: mostly modest sizes near the origin, sometimes anything at all.
    function automatic collider_t random_reference();
        collider_t r;
        r.kind = bco_pkg::bco_kind_t'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
        begin
            r.ax = pick_extreme();
            r.ay = pick_extreme();
            r.az = pick_extreme();
            r.bx = pick_extreme();
            r.by = pick_extreme();
            r.bz = pick_extreme();
        end
        else
        begin
            r.ax = clip(int'($urandom_range(0, 4000)) - 2000);
            r.ay = clip(int'($urandom_range(0, 4000)) - 2000);
            r.az = clip(int'($urandom_range(0, 4000)) - 2000);
            r.bz = clip(int'(r.az) + int'($urandom_range(0, 400)));
            if (r.kind == bco_pkg::KIND_CYL)
            begin
                r.bx = clip(int'($urandom_range(0, 300)));
                r.by = clip(int'($urandom_range(0, 400)));
            end
            else
            begin
                r.bx = clip(int'(r.ax) + int'($urandom_range(0, 400)));
                r.by = clip(int'(r.ay) + int'($urandom_range(0, 400)));
            end
        end
        return r;
    endfunction

    // Tested collider: mostly placed around the reference so that both
    // outcomes and the corner distance test come up; the rest is noise.
    function automatic collider_t random_item();
        collider_t c;
        extent_t   e;
        int        mode;
        int        cx;
        int        cy;
        int        cz;
        int        sx;
        int        sy;
        int        sz;
        mode = $urandom_range(0, 9);
        c.kind = bco_pkg::bco_kind_t'($urandom_range(0, 1));
        c.bz = coord_t'($urandom);
        if (mode < 2)
        begin
            c.ax = coord_t'($urandom);
            c.ay = coord_t'($urandom);
            c.az = coord_t'($urandom);
            c.bx = coord_t'($urandom);
            c.by = coord_t'($urandom);
        end
        else if (mode < 4)
        begin
            c.ax = pick_extreme();
            c.ay = pick_extreme();
            c.az = pick_extreme();
            c.bx = pick_extreme();
            c.by = pick_extreme();
            c.bz = pick_extreme();
        end
        else
        begin
            e = extent_of(shape_ref);
            cx = int'((e.x0 + e.x1) / 2) + int'($urandom_range(0, 800)) - 400;
            cy = int'((e.y0 + e.y1) / 2) + int'($urandom_range(0, 800)) - 400;
            cz = int'((e.z0 + e.z1) / 2) + int'($urandom_range(0, 800)) - 400;
            sx = $urandom_range(0, 200);
            sy = $urandom_range(0, 300);
            sz = $urandom_range(0, 200);
            // An occasional negative size turns the extent inside out.
            if ($urandom_range(0, 19) == 0)
                sx = -sx;
            if ($urandom_range(0, 19) == 0)
                sy = -sy;
            if (c.kind == bco_pkg::KIND_CYL)
            begin
                c.ax = clip(cx);
                c.ay = clip(cy - sy / 2);
                c.az = clip(cz);
                c.bx = clip(sx);
                c.by = clip(sy);
            end
            else
            begin
                c.ax = clip(cx - sx);
                c.ay = clip(cy - sy);
                c.az = clip(cz - sz);
                c.bx = clip(cx + sx);
                c.by = clip(cy + sy);
                c.bz = clip(cz + sz);
            end
        end
        return c;
    endfunction

    // One register write beat; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [bco_pkg::REG_INDEX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            bco_pkg::REG_KIND: shape_ref.kind = bco_pkg::bco_kind_t'(data[0]);
            bco_pkg::REG_AX: shape_ref.ax = data;
            bco_pkg::REG_AY: shape_ref.ay = data;
            bco_pkg::REG_AZ: shape_ref.az = data;
            bco_pkg::REG_BX: shape_ref.bx = data;
            bco_pkg::REG_BY: shape_ref.by = data;
            bco_pkg::REG_BZ: shape_ref.bz = data;
            default: ;
        endcase
    endtask

    // Load a reference collider. Upper bits of the kind write are junk, and
    // a write to the unused index is thrown in now and then.
    task automatic program_reference(input collider_t r);
        write_reg(bco_pkg::REG_KIND, {15'($urandom), r.kind});
        write_reg(bco_pkg::REG_AX, r.ax);
        write_reg(bco_pkg::REG_AY, r.ay);
        write_reg(bco_pkg::REG_AZ, r.az);
        write_reg(bco_pkg::REG_BX, r.bx);
        write_reg(bco_pkg::REG_BY, r.by);
        write_reg(bco_pkg::REG_BZ, r.bz);
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_UNUSED, COORD_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Send one tested collider and record the hit it should give.
    task automatic send_probe(input collider_t c, input want_t want);
        int   gap;
        logic due;
        gap = idle_draw();
        due = (want == WANT_MODEL) ? predict_hit(c) : (want == WANT_HIT);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_kind <= c.kind;
        item_ax <= c.ax;
        item_ay <= c.ay;
        item_az <= c.az;
        item_bx <= c.bx;
        item_by <= c.by;
        item_bz <= c.bz;
        do
            @(posedge clk);
        while (item_stall);
        hits_due.push_back(due);
    endtask

    // Let the pipeline empty out before touching the registers.
    task automatic drain();
        item_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Result side: random stall before each beat.
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = idle_draw();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    // Compare each result beat with the oldest expected hit.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (hits_due.size() == 0)
            begin
                $error("hit: result beat with nothing expected, actual %0b", hit);
                mismatches++;
            end
            else
            begin
                due_hit = hits_due.pop_front();
                if (hit !== due_hit)
                begin
                    $error("hit mismatch: expected %0b, actual %0b", due_hit, hit);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed probes, then random phases.
    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PROBES[i])
        begin
            if (PROBES[i].refc != shape_ref)
            begin
                drain();
                program_reference(PROBES[i].refc);
            end
            send_probe(PROBES[i].item, PROBES[i].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            program_reference(random_reference());
            calm = (phase % 3 == 2);
            repeat (PHASE_BEATS) send_probe(random_item(), WANT_MODEL);
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
